// ----- hw/rtl/kts_pkg.sv -----
// constants, tables and item types of the keyframe track sampler
`timescale 1ns / 1ps

package kts_pkg;

    localparam int MAX_KEYS_DEF     = 64;
    localparam int CORDIC_STEPS_DEF = 24;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration register indexes (byte address 4*index)
    localparam int         CFG_ADDR_W      = 4;
    localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
    localparam logic [1:0] REG_INTERP_MODE = 2'd1;
    localparam logic [1:0] REG_VALUE_KIND  = 2'd2;

    localparam logic [6:0] KEY_COUNT_RST   = 7'd0;
    localparam logic [1:0] INTERP_MODE_RST = 2'd1;
    localparam logic       VALUE_KIND_RST  = 1'b0;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic       KIND_VECTOR = 1'b0;
    localparam logic       KIND_QUAT   = 1'b1;

    // atan(2^-i) in Q2.30
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
        30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
        30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
        30'd31,        30'd15,        30'd7,         30'd3,         30'd1,
        30'd0,         30'd0
    };

    typedef struct packed {
        logic               command;
        logic        [5:0]  key_index;
        logic        [31:0] key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic signed [31:0] key_w;
        logic        [31:0] query_time;
    } kts_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               was_sample;
    } kts_out_t;

endpackage

// ----- hw/rtl/kts_chan_if.sv -----
// valid/ready channel carrying one item of a given type
`timescale 1ns / 1ps

interface kts_chan_if #(
    parameter type item_t = kts_pkg::kts_in_t
);
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ----- hw/rtl/keyframe_track_sampler.sv -----
// Keyframe track sampler: holds one track of keys and returns step, lerp or slerp
// samples through one shared multiplier, divider, square root and CORDIC unit under
// a sequencer. One item is taken at a time. A key write goes straight to the result
// stage. A sample runs a binary search over the key memory (one registered read per
// probe) and then reads the bounding keys; an interpolated sample then adds a
// bit-serial division for the factor and a multiply and add per vector component,
// while a quaternion slerp adds a dot product, a square root, four CORDIC runs and a
// multiply and divide per component. The key table is undefined after reset: sample
// only keys that have been written.
`timescale 1ns / 1ps

module keyframe_track_sampler #(
    parameter int MAX_KEYS     = kts_pkg::MAX_KEYS_DEF,
    parameter int CORDIC_STEPS = kts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kts_chan_if.sink                      req,
    kts_chan_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kts_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int NW = (CW > 7) ? CW : 7;

    typedef enum logic [24:0] {
        S_IDLE   = 25'h0000001,
        S_SRCH   = 25'h0000002,
        S_CMP    = 25'h0000004,
        S_RDEND  = 25'h0000008,
        S_ENDV   = 25'h0000010,
        S_RD0    = 25'h0000020,
        S_RD1    = 25'h0000040,
        S_GOT1   = 25'h0000080,
        S_DIV    = 25'h0000100,
        S_FOK    = 25'h0000200,
        S_LMUL   = 25'h0000400,
        S_LADD   = 25'h0000800,
        S_DOT    = 25'h0001000,
        S_DACC   = 25'h0002000,
        S_DSIGN  = 25'h0004000,
        S_DSQ    = 25'h0008000,
        S_SQINIT = 25'h0010000,
        S_SQRT   = 25'h0020000,
        S_CORD   = 25'h0040000,
        S_SMUL   = 25'h0080000,
        S_SINIT  = 25'h0100000,
        S_PMULA  = 25'h0200000,
        S_PMULB  = 25'h0400000,
        S_PACC   = 25'h0800000,
        S_OUT    = 25'h1000000
    } state_t;

    localparam logic [30:0]        Q30_ONE     = 31'd1073741824;
    localparam logic signed [35:0] SLERP_LIMIT = 36'sd1073741696;

    function automatic logic signed [31:0] sat72(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // truncating signed quotient from magnitude and sign, saturated
    function automatic logic signed [31:0] sat_quot(input logic [63:0] qv, input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            if (qv > 64'h0000_0000_8000_0000)
                r = 32'sh80000000;
            else
                r = ~qv[31:0] + 32'd1;
        end
        else
        begin
            if (qv > 64'h0000_0000_7fff_ffff)
                r = 32'sh7fffffff;
            else
                r = qv[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [6:0] key_count_reg;
    logic [1:0] interp_mode_reg;
    logic       value_kind_reg;
    logic       cfg_we;

    // control
    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   load_out;

    // key memory
    logic [31:0]  time_mem [MAX_KEYS];
    logic [127:0] val_mem  [MAX_KEYS];
    logic [31:0]  time_rd_reg;
    logic [127:0] val_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // datapath
    logic [31:0]        t_reg, t_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      end_idx_reg, end_idx_next;
    logic [31:0]        t0_reg, t0_next;
    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic signed [32:0] q_reg [4];
    logic signed [32:0] q_next [4];
    logic [30:0]        f_reg, f_next;
    logic [1:0]         k_reg, k_next;
    logic signed [35:0] d_reg, d_next;
    logic [63:0]        sq_u_reg, sq_u_next;
    logic [63:0]        sq_res_reg, sq_res_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;
    logic signed [35:0] cx_reg, cx_next;
    logic signed [35:0] cy_reg, cy_next;
    logic signed [35:0] cz_reg, cz_next;
    logic               rot_reg, rot_next;
    logic [6:0]         iter_reg, iter_next;
    logic signed [33:0] theta_reg, theta_next;
    logic [1:0]         sin_sel_reg, sin_sel_next;
    logic signed [33:0] sa_reg, sa_next;
    logic signed [33:0] sb_reg, sb_next;
    logic signed [33:0] st_reg, st_next;
    logic signed [67:0] acc_reg, acc_next;
    logic [31:0]        div_rem_reg, div_rem_next;
    logic [63:0]        div_q_reg, div_q_next;
    logic [31:0]        div_d_reg, div_d_next;
    logic               div_neg_reg, div_neg_next;
    logic               div_slerp_reg, div_slerp_next;
    logic signed [31:0] res_reg [4];
    logic signed [31:0] res_next [4];
    logic               res_sample_reg, res_sample_next;
    kts_pkg::kts_out_t  out_item_reg;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p_reg;

    // iteration units
    logic [CW-1:0]      step_c;
    logic [CW-1:0]      probe_lo, probe_cnt;
    logic [NW-1:0]      n_sel;
    logic [32:0]        div_trial;
    logic               div_ge;
    logic [31:0]        div_rem_n;
    logic [63:0]        div_quot_n;
    logic [63:0]        sq_rb;
    logic [63:0]        sq_u_n, sq_res_n;
    logic               cord_ccw;
    logic signed [35:0] cx_sh, cy_sh, c_atan;
    logic signed [35:0] cx_n, cy_n, cz_n;
    logic [1:0]         last_k;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            kts_pkg::REG_KEY_COUNT:   prdata = {25'd0, key_count_reg};
            kts_pkg::REG_INTERP_MODE: prdata = {30'd0, interp_mode_reg};
            kts_pkg::REG_VALUE_KIND:  prdata = {31'd0, value_kind_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    assign mem_we = req.valid && req.ready && (req.item.command == kts_pkg::CMD_WRITE)
                    && (32'(req.item.key_index) < 32'(MAX_KEYS));

    assign n_sel = (NW'(key_count_reg) < NW'(MAX_KEYS)) ? NW'(key_count_reg) : NW'(MAX_KEYS);

    // ---------------- key memory ----------------
    always_comb
    begin
        unique case (state_reg)
            S_SRCH:  rd_addr = AW'(lo_reg + step_c);
            S_RDEND: rd_addr = end_idx_reg;
            S_RD0:   rd_addr = AW'(lo_reg - CW'(1));
            S_RD1:   rd_addr = AW'(lo_reg);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[AW'(req.item.key_index)] <= req.item.key_time;
            val_mem[AW'(req.item.key_index)]  <= {req.item.key_w, req.item.key_z,
                                                  req.item.key_y, req.item.key_x};
        end
        time_rd_reg <= time_mem[rd_addr];
        val_rd_reg  <= val_mem[rd_addr];
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LMUL:
            begin
                mul_a = 34'(q_reg[k_reg]) - 34'(p_reg[k_reg]);
                mul_b = {3'b000, f_reg};
            end
            S_DOT:
            begin
                mul_a = 34'(p_reg[k_reg]);
                mul_b = 34'(q_reg[k_reg]);
            end
            S_DSQ:
            begin
                mul_a = d_reg[33:0];
                mul_b = d_reg[33:0];
            end
            S_SMUL:
            begin
                mul_a = theta_reg;
                mul_b = (sin_sel_reg == 2'd0) ? {3'b000, Q30_ONE - f_reg} : {3'b000, f_reg};
            end
            S_PMULA:
            begin
                mul_a = sa_reg;
                mul_b = 34'(p_reg[k_reg]);
            end
            S_PMULB:
            begin
                mul_a = sb_reg;
                mul_b = 34'(q_reg[k_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // ---------------- iteration steps ----------------
    assign step_c    = cnt_reg >> 1;
    assign probe_lo  = lo_reg + step_c + CW'(1);
    assign probe_cnt = cnt_reg - step_c - CW'(1);

    // restoring divider, one quotient bit a cycle
    assign div_trial  = {div_rem_reg, div_q_reg[63]};
    assign div_ge     = div_trial >= {1'b0, div_d_reg};
    assign div_rem_n  = div_ge ? 32'(div_trial - {1'b0, div_d_reg}) : div_trial[31:0];
    assign div_quot_n = {div_q_reg[62:0], div_ge};

    // integer square root, one result bit a cycle
    assign sq_rb    = sq_res_reg + sq_bit_reg;
    assign sq_u_n   = (sq_u_reg >= sq_rb) ? (sq_u_reg - sq_rb) : sq_u_reg;
    assign sq_res_n = (sq_u_reg >= sq_rb) ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    // cordic: vectoring drives y to zero, rotation drives z to zero
    assign cord_ccw = rot_reg ? (cz_reg >= 0) : (cy_reg < 0);
    assign cx_sh    = cx_reg >>> iter_reg[4:0];
    assign cy_sh    = cy_reg >>> iter_reg[4:0];
    assign c_atan   = {6'd0, kts_pkg::ATAN_Q30[iter_reg[4:0]]};
    assign cx_n     = cord_ccw ? (cx_reg - cy_sh) : (cx_reg + cy_sh);
    assign cy_n     = cord_ccw ? (cy_reg + cx_sh) : (cy_reg - cx_sh);
    assign cz_n     = cord_ccw ? (cz_reg - c_atan) : (cz_reg + c_atan);

    assign last_k = (value_kind_reg == kts_pkg::KIND_QUAT) ? 2'd3 : 2'd2;

    // ---------------- sequencer ----------------
    always_comb
    begin
        logic [31:0]        t1;
        logic [31:0]        dt;
        logic [31:0]        span;
        logic signed [71:0] lerp_sum;
        logic signed [35:0] dabs;
        logic signed [67:0] pair_sum;

        state_next      = state_reg;
        t_next          = t_reg;
        n_next          = n_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        end_idx_next    = end_idx_reg;
        t0_next         = t0_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        f_next          = f_reg;
        k_next          = k_reg;
        d_next          = d_reg;
        sq_u_next       = sq_u_reg;
        sq_res_next     = sq_res_reg;
        sq_bit_next     = sq_bit_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        rot_next        = rot_reg;
        iter_next       = iter_reg;
        theta_next      = theta_reg;
        sin_sel_next    = sin_sel_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        st_next         = st_reg;
        acc_next        = acc_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        div_d_next      = div_d_reg;
        div_neg_next    = div_neg_reg;
        div_slerp_next  = div_slerp_reg;
        res_next        = res_reg;
        res_sample_next = res_sample_reg;

        t1       = time_rd_reg;
        dt       = t_reg - t0_reg;
        span     = t1 - t0_reg;
        lerp_sum = 72'(p_reg[k_reg]) + ((72'(mul_p_reg) + 72'sd536870912) >>> 30);
        dabs     = (d_reg < 0) ? -d_reg : d_reg;
        pair_sum = acc_reg + mul_p_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    for (int c = 0; c < 4; c++)
                        res_next[c] = '0;
                    if (req.item.command == kts_pkg::CMD_WRITE)
                    begin
                        res_sample_next = 1'b0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        res_sample_next = 1'b1;
                        t_next          = req.item.query_time;
                        n_next          = CW'(n_sel);
                        if (n_sel == NW'(0))
                        begin
                            if (value_kind_reg == kts_pkg::KIND_QUAT)
                                res_next[3] = 32'sd1073741824;
                            state_next = S_OUT;
                        end
                        else if (n_sel == NW'(1))
                        begin
                            end_idx_next = '0;
                            state_next   = S_RDEND;
                        end
                        else
                        begin
                            lo_next    = '0;
                            cnt_next   = CW'(n_sel);
                            state_next = S_SRCH;
                        end
                    end
                end
            end

            S_SRCH:
                state_next = S_CMP;

            S_CMP:
            begin
                logic [CW-1:0] lo_n;
                logic [CW-1:0] cnt_n;
                if (time_rd_reg < t_reg)
                begin
                    lo_n  = probe_lo;
                    cnt_n = probe_cnt;
                end
                else
                begin
                    lo_n  = lo_reg;
                    cnt_n = step_c;
                end
                lo_next  = lo_n;
                cnt_next = cnt_n;
                if (cnt_n != CW'(0))
                    state_next = S_SRCH;
                else if (lo_n == CW'(0))
                begin
                    end_idx_next = '0;
                    state_next   = S_RDEND;
                end
                else if (lo_n >= n_reg)
                begin
                    end_idx_next = AW'(n_reg - CW'(1));
                    state_next   = S_RDEND;
                end
                else
                    state_next = S_RD0;
            end

            S_RDEND:
                state_next = S_ENDV;

            S_ENDV:
            begin
                for (int c = 0; c < 4; c++)
                    res_next[c] = $signed(val_rd_reg[32*c +: 32]);
                if (value_kind_reg == kts_pkg::KIND_VECTOR)
                    res_next[3] = '0;
                state_next = S_OUT;
            end

            S_RD0:
                state_next = S_RD1;

            S_RD1:
            begin
                t0_next = time_rd_reg;
                for (int c = 0; c < 4; c++)
                    p_next[c] = $signed(val_rd_reg[32*c +: 32]);
                state_next = S_GOT1;
            end

            S_GOT1:
            begin
                for (int c = 0; c < 4; c++)
                    q_next[c] = 33'($signed(val_rd_reg[32*c +: 32]));
                if (interp_mode_reg == kts_pkg::MODE_STEP)
                begin
                    res_next = p_reg;
                    if (value_kind_reg == kts_pkg::KIND_VECTOR)
                        res_next[3] = '0;
                    state_next = S_OUT;
                end
                else if (t1 <= t0_reg || dt >= span)
                begin
                    f_next     = Q30_ONE;
                    state_next = S_FOK;
                end
                else
                begin
                    div_q_next     = {2'b00, dt, 30'd0};
                    div_d_next     = span;
                    div_rem_next   = '0;
                    div_slerp_next = 1'b0;
                    iter_next      = '0;
                    state_next     = S_DIV;
                end
            end

            S_DIV:
            begin
                div_rem_next = div_rem_n;
                div_q_next   = div_quot_n;
                iter_next    = iter_reg + 7'd1;
                if (iter_reg == 7'd63)
                begin
                    if (div_slerp_reg)
                    begin
                        res_next[k_reg] = sat_quot(div_quot_n, div_neg_reg);
                        if (k_reg == 2'd3)
                            state_next = S_OUT;
                        else
                        begin
                            k_next     = k_reg + 2'd1;
                            state_next = S_PMULA;
                        end
                    end
                    else
                    begin
                        f_next     = div_quot_n[30:0];
                        state_next = S_FOK;
                    end
                end
            end

            S_FOK:
            begin
                k_next = '0;
                d_next = '0;
                for (int c = 0; c < 4; c++)
                    res_next[c] = '0;
                if (value_kind_reg == kts_pkg::KIND_QUAT)
                    state_next = S_DOT;
                else
                    state_next = S_LMUL;
            end

            S_LMUL:
                state_next = S_LADD;

            S_LADD:
            begin
                res_next[k_reg] = sat72(lerp_sum);
                if (k_reg == last_k)
                    state_next = S_OUT;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_LMUL;
                end
            end

            S_DOT:
                state_next = S_DACC;

            S_DACC:
            begin
                d_next = d_reg + 36'(mul_p_reg >>> 30);
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    state_next = S_DSIGN;
                else
                    state_next = S_DOT;
            end

            S_DSIGN:
            begin
                // take the shorter arc
                if (d_reg < 0)
                begin
                    for (int c = 0; c < 4; c++)
                        q_next[c] = -q_reg[c];
                end
                d_next = dabs;
                k_next = '0;
                if (dabs > SLERP_LIMIT)
                    state_next = S_LMUL;
                else
                    state_next = S_DSQ;
            end

            S_DSQ:
                state_next = S_SQINIT;

            S_SQINIT:
            begin
                sq_u_next   = 64'h1000_0000_0000_0000 - mul_p_reg[63:0];
                sq_res_next = '0;
                sq_bit_next = 64'h1000_0000_0000_0000;
                iter_next   = '0;
                state_next  = S_SQRT;
            end

            S_SQRT:
            begin
                sq_u_next   = sq_u_n;
                sq_res_next = sq_res_n;
                sq_bit_next = sq_bit_reg >> 2;
                iter_next   = iter_reg + 7'd1;
                if (iter_reg == 7'd30)
                begin
                    cx_next    = d_reg;
                    cy_next    = 36'(sq_res_n);
                    cz_next    = '0;
                    rot_next   = 1'b0;
                    iter_next  = '0;
                    state_next = S_CORD;
                end
            end

            S_CORD:
            begin
                cx_next   = cx_n;
                cy_next   = cy_n;
                cz_next   = cz_n;
                iter_next = iter_reg + 7'd1;
                if (iter_reg == 7'(CORDIC_STEPS - 1))
                begin
                    if (!rot_reg)
                    begin
                        theta_next   = cz_n[33:0];
                        sin_sel_next = '0;
                        k_next       = '0;
                        if (cz_n <= 0)
                            state_next = S_LMUL;
                        else
                            state_next = S_SMUL;
                    end
                    else
                    begin
                        unique case (sin_sel_reg)
                            2'd0:    sa_next = cy_n[33:0];
                            2'd1:    sb_next = cy_n[33:0];
                            default: st_next = cy_n[33:0];
                        endcase
                        k_next       = '0;
                        sin_sel_next = sin_sel_reg + 2'd1;
                        if (sin_sel_reg != 2'd2)
                            state_next = S_SMUL;
                        else if (cy_n <= 0)
                            state_next = S_LMUL;
                        else
                            state_next = S_PMULA;
                    end
                end
            end

            S_SMUL:
                state_next = S_SINIT;

            S_SINIT:
            begin
                cz_next    = (sin_sel_reg == 2'd2) ? 36'(theta_reg) : 36'(mul_p_reg >>> 30);
                cx_next    = 36'sd1073741824;
                cy_next    = '0;
                rot_next   = 1'b1;
                iter_next  = '0;
                state_next = S_CORD;
            end

            S_PMULA:
                state_next = S_PMULB;

            S_PMULB:
            begin
                acc_next   = mul_p_reg;
                state_next = S_PACC;
            end

            S_PACC:
            begin
                div_q_next     = (pair_sum < 0) ? 64'(-pair_sum) : 64'(pair_sum);
                div_neg_next   = pair_sum < 0;
                div_d_next     = st_reg[31:0];
                div_rem_next   = '0;
                div_slerp_next = 1'b1;
                iter_next      = '0;
                state_next     = S_DIV;
            end

            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            key_count_reg   <= kts_pkg::KEY_COUNT_RST;
            interp_mode_reg <= kts_pkg::INTERP_MODE_RST;
            value_kind_reg  <= kts_pkg::VALUE_KIND_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (paddr[3:2])
                    kts_pkg::REG_KEY_COUNT:   key_count_reg   <= pwdata[6:0];
                    kts_pkg::REG_INTERP_MODE: interp_mode_reg <= pwdata[1:0];
                    kts_pkg::REG_VALUE_KIND:  value_kind_reg  <= pwdata[0];
                    default:                  key_count_reg   <= key_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        n_reg          <= n_next;
        lo_reg         <= lo_next;
        cnt_reg        <= cnt_next;
        end_idx_reg    <= end_idx_next;
        t0_reg         <= t0_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        f_reg          <= f_next;
        k_reg          <= k_next;
        d_reg          <= d_next;
        sq_u_reg       <= sq_u_next;
        sq_res_reg     <= sq_res_next;
        sq_bit_reg     <= sq_bit_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        rot_reg        <= rot_next;
        iter_reg       <= iter_next;
        theta_reg      <= theta_next;
        sin_sel_reg    <= sin_sel_next;
        sa_reg         <= sa_next;
        sb_reg         <= sb_next;
        st_reg         <= st_next;
        acc_reg        <= acc_next;
        div_rem_reg    <= div_rem_next;
        div_q_reg      <= div_q_next;
        div_d_reg      <= div_d_next;
        div_neg_reg    <= div_neg_next;
        div_slerp_reg  <= div_slerp_next;
        res_reg        <= res_next;
        res_sample_reg <= res_sample_next;
        if (load_out)
        begin
            out_item_reg.out_x      <= res_reg[0];
            out_item_reg.out_y      <= res_reg[1];
            out_item_reg.out_z      <= res_reg[2];
            out_item_reg.out_w      <= res_reg[3];
            out_item_reg.was_sample <= res_sample_reg;
        end
    end

    // ---------------- assertions ----------------
    a_write_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.item.command == kts_pkg::CMD_WRITE |=> state_reg == S_OUT)
        else $error("key write did not go straight to the result stage");

    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FOK |-> f_reg <= Q30_ONE)
        else $error("interpolation factor above one");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_d_reg != 32'd0)
        else $error("divider started with a zero divisor");

    a_dot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DSQ |-> d_reg >= 0 && d_reg <= SLERP_LIMIT)
        else $error("slerp entered with dot product out of range");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && !rsp.ready |=> state_reg == S_OUT)
        else $error("result overwrote an item not yet taken");

endmodule
